// File: rtl/core/gg_pkg.sv
// ----------------------------------------------------------------------------
// gg_pkg
// Types, constants and exp tables shared by the Gaussian gridding weight unit.
// ----------------------------------------------------------------------------
package gg_pkg;

	localparam int COORD_W    = 17;
	localparam int FRAC_W     = 8;
	localparam int VOL_W      = 16;
	localparam int WT_W       = 16;
	localparam int IDX_W      = 21;
	localparam int ENT_W      = 24;
	localparam int GRID_W     = 8;
	localparam int WIN_W      = 3;
	localparam int KRN_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int GRID_MAX   = 128;
	localparam int WIN_MAX    = 4;
	localparam logic [ENT_W-1:0] ENT_MAX = {ENT_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_X   = 3'd0,
		REG_GRID_Y   = 3'd1,
		REG_GRID_Z   = 3'd2,
		REG_WINDOW   = 3'd3,
		REG_GAIN     = 3'd4,
		REG_EXPONENT = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH,
		ST_DRAIN
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic en;
		logic last_cand;
		logic win_zero;
		logic done;
	} dp_stat_t;

	// exp(-i), Q.16
	function automatic logic [16:0] exp_int(input logic [3:0] i);
		logic [16:0] v;
		case (i)
			4'd0:    v = 17'd65536;
			4'd1:    v = 17'd24110;
			4'd2:    v = 17'd8869;
			4'd3:    v = 17'd3263;
			4'd4:    v = 17'd1200;
			4'd5:    v = 17'd442;
			4'd6:    v = 17'd162;
			4'd7:    v = 17'd60;
			4'd8:    v = 17'd22;
			4'd9:    v = 17'd8;
			4'd10:   v = 17'd3;
			4'd11:   v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	// exp(-h/16), Q.16
	function automatic logic [16:0] exp_hi(input logic [3:0] h);
		logic [16:0] v;
		case (h)
			4'd0:    v = 17'd65536;
			4'd1:    v = 17'd61565;
			4'd2:    v = 17'd57835;
			4'd3:    v = 17'd54331;
			4'd4:    v = 17'd51039;
			4'd5:    v = 17'd47947;
			4'd6:    v = 17'd45042;
			4'd7:    v = 17'd42313;
			4'd8:    v = 17'd39750;
			4'd9:    v = 17'd37341;
			4'd10:   v = 17'd35079;
			4'd11:   v = 17'd32954;
			4'd12:   v = 17'd30957;
			4'd13:   v = 17'd29081;
			4'd14:   v = 17'd27319;
			default: v = 17'd25664;
		endcase
		return v;
	endfunction

	// exp(-l/256), Q.16
	function automatic logic [16:0] exp_lo(input logic [3:0] l);
		logic [16:0] v;
		case (l)
			4'd0:    v = 17'd65536;
			4'd1:    v = 17'd65280;
			4'd2:    v = 17'd65026;
			4'd3:    v = 17'd64772;
			4'd4:    v = 17'd64520;
			4'd5:    v = 17'd64268;
			4'd6:    v = 17'd64018;
			4'd7:    v = 17'd63768;
			4'd8:    v = 17'd63520;
			4'd9:    v = 17'd63272;
			4'd10:   v = 17'd63025;
			4'd11:   v = 17'd62780;
			4'd12:   v = 17'd62535;
			4'd13:   v = 17'd62291;
			4'd14:   v = 17'd62048;
			default: v = 17'd61806;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/core/gg_if.sv
// ----------------------------------------------------------------------------
// gg_if
// Sample and result channels of the gridding weight unit.
// ----------------------------------------------------------------------------
interface gg_sample_if;
	import gg_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [COORD_W-1:0]  coord_x;
	logic signed [COORD_W-1:0]  coord_y;
	logic signed [COORD_W-1:0]  coord_z;
	logic [VOL_W-1:0]           volume_element;
	logic                       last_point;

	modport source (output valid, coord_x, coord_y, coord_z, volume_element, last_point,
		input ready);
	modport sink (input valid, coord_x, coord_y, coord_z, volume_element, last_point,
		output ready);
endinterface

interface gg_result_if;
	import gg_pkg::*;
	logic              valid;
	logic              ready;
	logic [WT_W-1:0]   weight;
	logic [IDX_W-1:0]  grid_index;
	logic [ENT_W-1:0]  entry_number;
	logic              last_of_point;

	modport source (output valid, weight, grid_index, entry_number, last_of_point,
		input ready);
	modport sink (input valid, weight, grid_index, entry_number, last_of_point,
		output ready);
endinterface

// File: rtl/core/gaussian_gridding_weight_gen_unit.sv
// ----------------------------------------------------------------------------
// gaussian_gridding_weight_gen_unit
// Gaussian gridding weights, grid indices and entry numbers for 3D samples.
// ----------------------------------------------------------------------------
//  channel  | role   | beat
//  sample   | sink   | coord_x/y/z, volume_element, last_point
//  result   | source | weight, grid_index, entry_number, last_of_point
//  cfg      | write  | cfg_we, cfg_idx, cfg_data
//
//  A sample passes through an accept step, a walk over its window_size^3
//  candidate neighbours (one candidate neighbour per cycle while the result
//  is not stalled), a flush step and a drain while the flush token crosses
//  the weight pipeline; at window zero the walk is skipped.
//  arst_n clears control state and sets the config registers to defaults.
//  A stalled result freezes the whole pipeline; one sample is in work at a time.
// ----------------------------------------------------------------------------
module gaussian_gridding_weight_gen_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [gg_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [gg_pkg::CFG_DATA_W-1:0]   cfg_data,
	gg_sample_if.sink                       sample,
	gg_result_if.source                     result
);
	import gg_pkg::*;

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	ctrl_state_t state;

	gg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.stat     (stat),
		.cmd      (cmd),
		.state    (state)
	);

	gg_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_idx           (cfg_idx),
		.cfg_data          (cfg_data),
		.coord_x           (sample.coord_x),
		.coord_y           (sample.coord_y),
		.coord_z           (sample.coord_z),
		.volume_element    (sample.volume_element),
		.last_point        (sample.last_point),
		.cmd               (cmd),
		.stat              (stat),
		.res_valid         (result.valid),
		.res_ready         (result.ready),
		.res_weight        (result.weight),
		.res_grid_index    (result.grid_index),
		.res_entry_number  (result.entry_number),
		.res_last_of_point (result.last_of_point)
	);

	a_one_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> !sample.ready)
		else $error("second sample accepted while one is in work");

	a_done_drain: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (state == ST_DRAIN))
		else $error("flush token left pipeline outside drain");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state == ST_IDLE) |-> !(cmd.step || cmd.flush))
		else $error("walk command while idle");

endmodule

// File: rtl/core/gg_ctrl.sv
// ----------------------------------------------------------------------------
// gg_ctrl
// Sequencer: accepts a sample, walks its window, flushes and waits for drain.
// ----------------------------------------------------------------------------
module gg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gg_pkg::dp_stat_t  stat,
	output gg_pkg::dp_cmd_t   cmd,
	output gg_pkg::ctrl_state_t state
);
	import gg_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = stat.win_zero ? ST_FLUSH : ST_WALK;
				end
			end
			ST_WALK: begin
				if (stat.en && stat.last_cand) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (stat.en) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_WALK:  cmd.step  = 1'b1;
			ST_FLUSH: cmd.flush = 1'b1;
			ST_DRAIN: ;
			default: ;
		endcase
	end

	assign state = state_q;

endmodule

// File: rtl/core/gg_datapath.sv
// ----------------------------------------------------------------------------
// gg_datapath
// Config registers, window walk counters, weight pipeline and result output.
// ----------------------------------------------------------------------------
module gg_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [gg_pkg::CFG_IDX_W-1:0]           cfg_idx,
	input  logic [gg_pkg::CFG_DATA_W-1:0]          cfg_data,
	input  logic signed [gg_pkg::COORD_W-1:0]      coord_x,
	input  logic signed [gg_pkg::COORD_W-1:0]      coord_y,
	input  logic signed [gg_pkg::COORD_W-1:0]      coord_z,
	input  logic [gg_pkg::VOL_W-1:0]               volume_element,
	input  logic                                   last_point,
	input  gg_pkg::dp_cmd_t                        cmd,
	output gg_pkg::dp_stat_t                       stat,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output logic [gg_pkg::WT_W-1:0]                res_weight,
	output logic [gg_pkg::IDX_W-1:0]               res_grid_index,
	output logic [gg_pkg::ENT_W-1:0]               res_entry_number,
	output logic                                   res_last_of_point
);
	import gg_pkg::*;

	// configuration
	logic [GRID_W-1:0] grid_q [3];
	logic [WIN_W-1:0]  win_q;
	logic [KRN_W-1:0]  gain_q, expo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q[0] <= GRID_W'(GRID_MAX);
			grid_q[1] <= GRID_W'(GRID_MAX);
			grid_q[2] <= GRID_W'(GRID_MAX);
			win_q     <= WIN_W'(3);
			gain_q    <= KRN_W'(4096);
			expo_q    <= KRN_W'(512);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_GRID_X:   grid_q[0] <= cfg_data[GRID_W-1:0];
				REG_GRID_Y:   grid_q[1] <= cfg_data[GRID_W-1:0];
				REG_GRID_Z:   grid_q[2] <= cfg_data[GRID_W-1:0];
				REG_WINDOW:   win_q     <= cfg_data[WIN_W-1:0];
				REG_GAIN:     gain_q    <= cfg_data;
				REG_EXPONENT: expo_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [GRID_W-1:0] nsz [3];
	logic [WIN_W-1:0]  w;
	logic              odd, half;
	logic [1:0]        wm1;
	logic [18:0]       dmax;
	logic [5:0]        w_sq;
	logic [14:0]       plane;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			nsz[a] = (grid_q[a] > GRID_W'(GRID_MAX)) ? GRID_W'(GRID_MAX) : grid_q[a];
		end
		w     = (win_q > WIN_W'(WIN_MAX)) ? WIN_W'(WIN_MAX) : win_q;
		odd   = w[0];
		half  = (w >= WIN_W'(3));
		wm1   = 2'(w - WIN_W'(1));
		w_sq  = 6'(w) * 6'(w);
		dmax  = {w_sq[4:0], 14'b0};
		plane = 15'(nsz[0]) * 15'(nsz[1]);
	end

	// per-sample values
	logic signed [9:0]  r_q    [3];
	logic signed [10:0] base_q [3];
	logic [VOL_W-1:0]   vol_q;
	logic               lastpt_q;
	logic [1:0]         k_q    [3];

	logic signed [COORD_W-1:0] coord [3];
	logic signed [COORD_W:0]   sh    [3];

	assign coord[0] = coord_x;
	assign coord[1] = coord_y;
	assign coord[2] = coord_z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sh[a] = $signed({coord[a][COORD_W-1], coord[a]})
				+ $signed({10'b0, odd, 7'b0});
		end
	end

	logic en;
	logic res_v_q;

	assign en = !res_v_q || res_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int a = 0; a < 3; a++) begin
				r_q[a]    <= $signed({2'b0, sh[a][7:0]}) - $signed({2'b0, odd, 7'b0});
				base_q[a] <= 11'(sh[a] >>> FRAC_W) - 11'sd1 - $signed({10'b0, half});
			end
			vol_q    <= volume_element;
			lastpt_q <= last_point;
		end
	end

	logic last_cand;
	assign last_cand = (k_q[0] == wm1) && (k_q[1] == wm1) && (k_q[2] == wm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q[0] <= '0;
			k_q[1] <= '0;
			k_q[2] <= '0;
		end else if (cmd.load) begin
			k_q[0] <= '0;
			k_q[1] <= '0;
			k_q[2] <= '0;
		end else if (cmd.step && en) begin
			// x innermost, then y, then z
			if (k_q[0] == wm1) begin
				k_q[0] <= '0;
				if (k_q[1] == wm1) begin
					k_q[1] <= '0;
					k_q[2] <= k_q[2] + 2'd1;
				end else begin
					k_q[1] <= k_q[1] + 2'd1;
				end
			end else begin
				k_q[0] <= k_q[0] + 2'd1;
			end
		end
	end

	// stage 1: offsets and bounds
	logic signed [10:0] n   [3];
	logic signed [2:0]  kh  [3];
	logic signed [11:0] d   [3];
	logic               inb;

	always_comb begin
		inb = 1'b1;
		for (int a = 0; a < 3; a++) begin
			n[a]  = base_q[a] + $signed({9'b0, k_q[a]});
			kh[a] = $signed({1'b0, k_q[a]}) - $signed({2'b0, half});
			d[a]  = $signed({{2{r_q[a][9]}}, r_q[a]})
				- $signed({kh[a][2], kh[a], 8'b0});
			if (n[a] < 0 || n[a] >= $signed({3'b0, nsz[a]})) begin
				inb = 1'b0;
			end
		end
	end

	logic               v_s1, t_s1, inb_s1;
	logic signed [11:0] d_s1 [3];
	logic [6:0]         c_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			t_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= cmd.step;
			t_s1 <= cmd.flush;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inb_s1 <= inb;
			for (int a = 0; a < 3; a++) begin
				d_s1[a] <= d[a];
				c_s1[a] <= n[a][6:0];
			end
		end
	end

	// stage 2: squared distance, linear index
	logic signed [23:0] sq [3];
	logic [21:0] d2;
	logic [21:0] idx_full;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sq[a] = d_s1[a] * d_s1[a];
		end
		d2 = sq[0][21:0] + sq[1][21:0] + sq[2][21:0];
		idx_full = 22'(c_s1[0]) + 22'(c_s1[1]) * 22'(nsz[0])
			+ 22'(c_s1[2]) * 22'(plane);
	end

	logic              v_s2, t_s2;
	logic [21:0]       d2_s2;
	logic [IDX_W-1:0]  idx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			t_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && inb_s1 && (d2 < 22'(dmax));
			t_s2 <= t_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s2  <= d2;
			idx_s2 <= idx_full[IDX_W-1:0];
		end
	end

	// stage 3: exp argument, Q.8
	logic [37:0] arg_prod;
	assign arg_prod = 38'(expo_q) * 38'(d2_s2) + 38'(32768);

	logic              v_s3, t_s3;
	logic [21:0]       a8_s3;
	logic [IDX_W-1:0]  idx_s3;

	// stage 4: exp(-int) * exp(-hi)
	logic [33:0] e12_prod;
	assign e12_prod = 34'(exp_int(a8_s3[11:8])) * 34'(exp_hi(a8_s3[7:4])) + 34'(32768);

	logic              v_s4, t_s4, z_s4;
	logic [16:0]       e12_s4;
	logic [3:0]        lo_s4;
	logic [IDX_W-1:0]  idx_s4;

	// stage 5: times exp(-lo)
	logic [33:0] e_prod;
	assign e_prod = 34'(e12_s4) * 34'(exp_lo(lo_s4)) + 34'(32768);

	logic              v_s5, t_s5;
	logic [16:0]       e_s5;
	logic [IDX_W-1:0]  idx_s5;

	// stage 6: gain
	logic [32:0] g_prod;
	assign g_prod = 33'(gain_q) * 33'(e_s5) + 33'(32768);

	logic              v_s6, t_s6;
	logic [16:0]       g_s6;
	logic [IDX_W-1:0]  idx_s6;

	// stage 7: volume element, saturate
	logic [33:0] wt_prod;
	logic [21:0] wt_full;
	assign wt_prod = 34'(g_s6) * 34'(vol_q) + 34'(2048);
	assign wt_full = wt_prod[33:12];

	logic              v_s7, t_s7;
	logic [WT_W-1:0]   wt_s7;
	logic [IDX_W-1:0]  idx_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s3, t_s3, v_s4, t_s4, v_s5, t_s5, v_s6, t_s6, v_s7, t_s7} <= '0;
		end else if (en) begin
			v_s3 <= v_s2;  t_s3 <= t_s2;
			v_s4 <= v_s3;  t_s4 <= t_s3;
			v_s5 <= v_s4;  t_s5 <= t_s4;
			v_s6 <= v_s5;  t_s6 <= t_s5;
			v_s7 <= v_s6;  t_s7 <= t_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a8_s3  <= arg_prod[37:16];
			idx_s3 <= idx_s2;
			z_s4   <= (a8_s3[21:8] >= 14'd12);
			e12_s4 <= e12_prod[32:16];
			lo_s4  <= a8_s3[3:0];
			idx_s4 <= idx_s3;
			e_s5   <= z_s4 ? 17'd0 : e_prod[32:16];
			idx_s5 <= idx_s4;
			g_s6   <= g_prod[32:16];
			idx_s6 <= idx_s5;
			wt_s7  <= (wt_full > 22'(16'hFFFF)) ? 16'hFFFF : wt_full[WT_W-1:0];
			idx_s7 <= idx_s6;
		end
	end

	// hold one survivor back so the final one can be flagged on the flush token
	logic              hold_v_q;
	logic [WT_W-1:0]   hold_wt_q;
	logic [IDX_W-1:0]  hold_idx_q;
	logic [ENT_W-1:0]  cnt_q;
	logic [ENT_W-1:0]  cnt_inc;

	assign cnt_inc = (cnt_q == ENT_MAX) ? cnt_q : cnt_q + ENT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			res_v_q  <= 1'b0;
			cnt_q    <= '0;
		end else if (en) begin
			res_v_q <= 1'b0;
			if (v_s7) begin
				hold_v_q <= 1'b1;
				if (hold_v_q) begin
					res_v_q <= 1'b1;
					cnt_q   <= cnt_inc;
				end
			end else if (t_s7) begin
				hold_v_q <= 1'b0;
				res_v_q  <= hold_v_q;
				if (lastpt_q) begin
					cnt_q <= '0;
				end else if (hold_v_q) begin
					cnt_q <= cnt_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s7) begin
				hold_wt_q  <= wt_s7;
				hold_idx_q <= idx_s7;
			end
			if ((v_s7 || t_s7) && hold_v_q) begin
				res_weight        <= hold_wt_q;
				res_grid_index    <= hold_idx_q;
				res_entry_number  <= cnt_q;
				res_last_of_point <= t_s7;
			end
		end
	end

	assign res_valid      = res_v_q;
	assign stat.en        = en;
	assign stat.last_cand = last_cand;
	assign stat.win_zero  = (w == '0);
	assign stat.done      = en && t_s7;

endmodule
